// ===== rtl/core/cib_pkg.sv =====
// Shared constants, types and a helper function for the clipped icon blitter.
`default_nettype none

package cib_pkg;

   // Width of the coordinate and size registers.
   localparam int unsigned DIM_W = 13;
   // Width of the signed arithmetic that holds every coordinate sum.
   localparam int unsigned CALC_W = DIM_W + 2;
   // Width of the screen coordinates on the result channel.
   localparam int unsigned COORD_W = 12;
   // Largest icon or canvas size; larger register values saturate to it.
   localparam int unsigned MAX_DIM = 4096;
   // Width of the configuration register index.
   localparam int unsigned CSR_IDX_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_DEST_X        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_Y        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ICON_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ICON_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_FORMAT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd6;

   // Pixel formats.
   localparam logic FMT_BGR24  = 1'b0;
   localparam logic FMT_BGRA32 = 1'b1;

   // One source pixel together with its place in the icon.
   typedef struct packed {
      logic [7:0]       blue;
      logic [7:0]       green;
      logic [7:0]       red;
      logic [7:0]       alpha;
      logic [DIM_W-1:0] col;
      logic [DIM_W-1:0] srow;
      logic             empty;
      logic             done;
   } pixel_type;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] lim;
      lim = DIM_W'(MAX_DIM);
      return (v > lim) ? lim : v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/clipped_icon_blit_keyed.sv =====
// Clipped icon blitter with color key: top level with counters and two register stages.
//
// The block takes an icon's pixels on the req_ channel, one transfer per pixel, in
// stored bottom-up raster order without row padding. For every pixel it returns one
// result on the rsp_ channel: a write enable, the screen column and row, the ARGB
// color and a flag on the last pixel of the icon. When no write is made the
// coordinates and color are zero.
// Placement, icon size, canvas size and pixel format sit in registers written over
// the csr_ channel; csr_ready is always high. Write them only while no pixel is in
// flight.
// A pixel passes an input stage register and then the result register, which holds
// its result. One pixel is taken every cycle unless both stages are full; the
// throughput is set by the single pass of clipping logic between the two stages.
// When the receiver stalls, the result register holds and the input stage fills;
// req_ready drops only when both are full, so no pixel is lost or repeated.
// Reset clears the column and row counters and both stages, and loads the register
// reset values: origin zero, empty icon, 24-bit format, 4096 by 4096 canvas.
`default_nettype none

module clipped_icon_blit_keyed (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Configuration write channel.
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cib_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cib_pkg::DIM_W-1:0]          csr_wdata,
   // Pixel input channel.
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [7:0]                         req_pix_blue,
   input  wire logic [7:0]                         req_pix_green,
   input  wire logic [7:0]                         req_pix_red,
   input  wire logic [7:0]                         req_pix_alpha,
   // Result channel.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_write_enable,
   output logic [cib_pkg::COORD_W-1:0]             rsp_screen_col,
   output logic [cib_pkg::COORD_W-1:0]             rsp_screen_row,
   output logic [31:0]                             rsp_argb_color,
   output logic                                    rsp_icon_done
);

   localparam int unsigned DW = cib_pkg::DIM_W;
   localparam int unsigned CW = cib_pkg::CALC_W;
   localparam int unsigned PW = cib_pkg::COORD_W;

   // Configuration registers.
   logic [DW-1:0] dest_x_ff, dest_y_ff, icon_width_ff, icon_height_ff;
   logic [DW-1:0] screen_width_ff, screen_height_ff;
   logic          pixel_format_ff;

   // Position counters.
   logic [DW-1:0] col_ff, col_in;
   logic [DW-1:0] srow_ff, srow_in;

   // Pipeline registers.
   logic                  s1_valid_ff, s1_valid_in;
   cib_pkg::pixel_type    s1_ff, s1_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  we_ff, we_in;
   logic [PW-1:0]         scol_ff, scol_in;
   logic [PW-1:0]         srw_ff, srw_in;
   logic [31:0]           argb_ff, argb_in;
   logic                  done_ff, done_in;

   // Handshake.
   logic rsp_free, s1_move, req_fire;

   // Saturated sizes.
   logic [DW-1:0] iw_sat, ih_sat, sw_sat, sh_sat;
   logic          icon_empty, row_end, icon_end;

   // Clipping arithmetic.
   logic signed [CW-1:0] ox, oy, iw, ih, sw, sh, cw, ch, irow, col_s;
   logic                 origin_ok, in_clip, keyed, pix_we;
   logic [31:0]          color;
   logic signed [CW-1:0] sum_col, sum_row;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff        <= '0;
         dest_y_ff        <= '0;
         icon_width_ff    <= '0;
         icon_height_ff   <= '0;
         pixel_format_ff  <= cib_pkg::FMT_BGR24;
         screen_width_ff  <= DW'(cib_pkg::MAX_DIM);
         screen_height_ff <= DW'(cib_pkg::MAX_DIM);
      end else if (csr_valid) begin
         case (csr_index)
            cib_pkg::REG_DEST_X:        dest_x_ff        <= csr_wdata;
            cib_pkg::REG_DEST_Y:        dest_y_ff        <= csr_wdata;
            cib_pkg::REG_ICON_WIDTH:    icon_width_ff    <= csr_wdata;
            cib_pkg::REG_ICON_HEIGHT:   icon_height_ff   <= csr_wdata;
            cib_pkg::REG_PIXEL_FORMAT:  pixel_format_ff  <= csr_wdata[0];
            cib_pkg::REG_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            cib_pkg::REG_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || rsp_free;
   assign req_fire  = req_valid && req_ready;

   assign iw_sat = cib_pkg::sat_dim(icon_width_ff);
   assign ih_sat = cib_pkg::sat_dim(icon_height_ff);
   assign sw_sat = cib_pkg::sat_dim(screen_width_ff);
   assign sh_sat = cib_pkg::sat_dim(screen_height_ff);

   // Counter step for the pixel being transferred in. A counter past the size
   // (size changed mid-icon) still ends the row or the icon.
   always_comb begin
      icon_empty = (iw_sat == '0) || (ih_sat == '0);
      row_end    = col_ff >= (iw_sat - DW'(1));
      icon_end   = srow_ff >= (ih_sat - DW'(1));
      col_in     = col_ff;
      srow_in    = srow_ff;
      s1_in.blue  = req_pix_blue;
      s1_in.green = req_pix_green;
      s1_in.red   = req_pix_red;
      s1_in.alpha = req_pix_alpha;
      s1_in.col   = col_ff;
      s1_in.srow  = srow_ff;
      s1_in.empty = icon_empty;
      s1_in.done  = 1'b0;
      if (icon_empty) begin
         s1_in.done = 1'b1;
         col_in     = '0;
         srow_in    = '0;
      end else if (row_end) begin
         col_in = '0;
         if (icon_end) begin
            s1_in.done = 1'b1;
            srow_in    = '0;
         end else begin
            srow_in = srow_ff + DW'(1);
         end
      end else begin
         col_in = col_ff + DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         srow_ff <= '0;
      end else if (req_fire) begin
         col_ff  <= col_in;
         srow_ff <= srow_in;
      end
   end

   assign s1_valid_in = req_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
   end

   // Clipping, color key and screen address for the pixel in the input stage.
   always_comb begin
      ox    = CW'(signed'(dest_x_ff));
      oy    = CW'(signed'(dest_y_ff));
      iw    = signed'(CW'(iw_sat));
      ih    = signed'(CW'(ih_sat));
      sw    = signed'(CW'(sw_sat));
      sh    = signed'(CW'(sh_sat));
      col_s = signed'(CW'(s1_ff.col));
      origin_ok = (ox >= 0) && (ox < sw) && (oy >= 0) && (oy < sh);
      cw    = ((ox + iw) > sw) ? (sw - ox) : iw;
      ch    = ((oy + ih) > sh) ? (sh - oy) : ih;
      irow  = ih - CW'(1) - signed'(CW'(s1_ff.srow));
      in_clip = !s1_ff.empty && origin_ok && (irow >= 0) && (irow < ch) && (col_s < cw);
      if (pixel_format_ff == cib_pkg::FMT_BGR24) begin
         keyed = (s1_ff.red == 8'hFF) && (s1_ff.green == 8'hFF) && (s1_ff.blue == 8'hFF);
         color = {8'hFF, s1_ff.red, s1_ff.green, s1_ff.blue};
      end else begin
         keyed = (s1_ff.alpha == 8'h00);
         color = {s1_ff.alpha, s1_ff.red, s1_ff.green, s1_ff.blue};
      end
      pix_we  = in_clip && !keyed;
      sum_col = ox + col_s;
      sum_row = oy + irow;
      we_in   = pix_we;
      scol_in = pix_we ? sum_col[PW-1:0] : '0;
      srw_in  = pix_we ? sum_row[PW-1:0] : '0;
      argb_in = pix_we ? color : '0;
      done_in = s1_ff.done;
   end

   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         we_ff   <= we_in;
         scol_ff <= scol_in;
         srw_ff  <= srw_in;
         argb_ff <= argb_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_screen_col   = scol_ff;
   assign rsp_screen_row   = srw_ff;
   assign rsp_argb_color   = argb_ff;
   assign rsp_icon_done    = done_ff;

`ifndef NO_ASSERTIONS
   // The input side stalls only when both stages hold a pixel.
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled while a stage was free");

   // A result without a write carries zero coordinates and color.
   a_no_write_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_enable) |->
      (rsp_screen_col == '0 && rsp_screen_row == '0 && rsp_argb_color == '0))
      else $error("non-write result carries data");

   // An empty icon returns the counters to the start after every pixel.
   a_empty_counters : assert property (@(posedge clock) disable iff (reset)
      (req_fire && icon_empty) |=> (col_ff == '0 && srow_ff == '0))
      else $error("counters moved on an empty icon");

   // Reset leaves the counters at the first pixel.
   a_reset_counters : assert property (@(posedge clock)
      reset |=> (col_ff == '0 && srow_ff == '0 && !rsp_valid_ff && !s1_valid_ff))
      else $error("reset did not clear the counters and stages");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the clipped icon blitter with color key.
module testbench;
   import cib_pkg::*;

   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int PIXEL_TARGET  = 1650;
   localparam int MAX_REPORTS   = 10;
   // The register index space has one index with no register behind it.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   typedef enum logic {ACT_PIXEL, ACT_CSR} act_kind_e;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
   } src_pixel_t;

   typedef struct packed {
      act_kind_e              kind;
      src_pixel_t             pix;
      logic [CSR_IDX_W-1:0]   idx;
      logic [DIM_W-1:0]       data;
   } blit_op_t;

   typedef struct packed {
      logic               we;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [31:0]        argb;
      logic               done;
   } canvas_write_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_pix_blue = '0;
   logic [7:0]           req_pix_green = '0;
   logic [7:0]           req_pix_red = '0;
   logic [7:0]           req_pix_alpha = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_write_enable;
   logic [COORD_W-1:0]   rsp_screen_col;
   logic [COORD_W-1:0]   rsp_screen_row;
   logic [31:0]          rsp_argb_color;
   logic                 rsp_icon_done;

   clipped_icon_blit_keyed i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pix_blue     (req_pix_blue),
      .req_pix_green    (req_pix_green),
      .req_pix_red      (req_pix_red),
      .req_pix_alpha    (req_pix_alpha),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_screen_col   (rsp_screen_col),
      .rsp_screen_row   (rsp_screen_row),
      .rsp_argb_color   (rsp_argb_color),
      .rsp_icon_done    (rsp_icon_done)
   );

   always #4 clock = !clock;

   // Stimulus and scoreboard state.
   blit_op_t      blit_ops[$];
   canvas_write_t expected_writes[$];
   int            mismatches = 0;
   int            idle_run = 0;
   int            quiet_cycles = 0;
   int            planned_pixels = 0;
   int            plan_w = 0;
   int            plan_h = 0;
   int            req_gap = 0;
   int            req_calm = 0;
   int            rsp_stall = 0;
   int            rsp_calm = 0;
   bit            req_took = 1'b0;
   bit            csr_took = 1'b0;
   bit            rsp_took = 1'b0;

   // Predictor copy of the registers and the position counters.
   logic [DIM_W-1:0] cfg_dest_x = '0;
   logic [DIM_W-1:0] cfg_dest_y = '0;
   logic [DIM_W-1:0] cfg_icon_w = '0;
   logic [DIM_W-1:0] cfg_icon_h = '0;
   logic             cfg_format = FMT_BGR24;
   logic [DIM_W-1:0] cfg_screen_w = DIM_W'(MAX_DIM);
   logic [DIM_W-1:0] cfg_screen_h = DIM_W'(MAX_DIM);
   logic [DIM_W-1:0] col_pos = '0;
   logic [DIM_W-1:0] srow_pos = '0;

   function automatic int clamp_dim(logic [DIM_W-1:0] v);
      return (v > DIM_W'(MAX_DIM)) ? int'(MAX_DIM) : int'(v);
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
         REG_DEST_X:        cfg_dest_x = data;
         REG_DEST_Y:        cfg_dest_y = data;
         REG_ICON_WIDTH:    cfg_icon_w = data;
         REG_ICON_HEIGHT:   cfg_icon_h = data;
         REG_PIXEL_FORMAT:  cfg_format = data[0];
         REG_SCREEN_WIDTH:  cfg_screen_w = data;
         REG_SCREEN_HEIGHT: cfg_screen_h = data;
         default: ;
      endcase
   endfunction

   // Works out the canvas write for one pixel and advances the counters.
   function automatic canvas_write_t blit_pixel(src_pixel_t px);
      canvas_write_t res;
      int ox, oy, iw, ih, sw, sh, col, srow, cw, ch, drow, xpos, ypos;
      res  = '0;
      ox   = int'($signed(cfg_dest_x));
      oy   = int'($signed(cfg_dest_y));
      iw   = clamp_dim(cfg_icon_w);
      ih   = clamp_dim(cfg_icon_h);
      sw   = clamp_dim(cfg_screen_w);
      sh   = clamp_dim(cfg_screen_h);
      col  = int'(col_pos);
      srow = int'(srow_pos);
      if (iw == 0 || ih == 0) begin
         res.done = 1'b1;
         col_pos  = '0;
         srow_pos = '0;
      end else begin
         if (ox >= 0 && ox < sw && oy >= 0 && oy < sh) begin
            cw   = (ox + iw > sw) ? sw - ox : iw;
            ch   = (oy + ih > sh) ? sh - oy : ih;
            // Rows are stored bottom-up, so stored row zero lands at the bottom.
            drow = ih - 1 - srow;
            if (drow >= 0 && drow < ch && col < cw) begin
               if (cfg_format == FMT_BGR24) begin
                  if (!(px.red == 8'hFF && px.green == 8'hFF && px.blue == 8'hFF)) begin
                     res.we   = 1'b1;
                     res.argb = {8'hFF, px.red, px.green, px.blue};
                  end
               end else if (px.alpha != 8'h00) begin
                  res.we   = 1'b1;
                  res.argb = {px.alpha, px.red, px.green, px.blue};
               end
               if (res.we) begin
                  xpos    = ox + col;
                  ypos    = oy + drow;
                  res.col = xpos[COORD_W-1:0];
                  res.row = ypos[COORD_W-1:0];
               end
            end
         end
         if (col >= iw - 1) begin
            col_pos = '0;
            if (srow >= ih - 1) begin
               res.done = 1'b1;
               srow_pos = '0;
            end else begin
               srow_pos = DIM_W'(srow + 1);
            end
         end else begin
            col_pos = DIM_W'(col + 1);
         end
      end
      return res;
   endfunction

   task automatic queue_write(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      blit_op_t op;
      op      = '0;
      op.kind = ACT_CSR;
      op.idx  = idx;
      op.data = data;
      blit_ops.push_back(op);
      if (idx == REG_ICON_WIDTH) plan_w = clamp_dim(data);
      if (idx == REG_ICON_HEIGHT) plan_h = clamp_dim(data);
   endtask

   task automatic queue_pixel(src_pixel_t px);
      blit_op_t op;
      op      = '0;
      op.kind = ACT_PIXEL;
      op.pix  = px;
      blit_ops.push_back(op);
      planned_pixels++;
   endtask

   // Mostly random colors, with plenty of white keys, near-whites and zero alphas.
   function automatic src_pixel_t random_pixel();
      src_pixel_t px;
      int roll;
      px   = src_pixel_t'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         px.blue  = 8'hFF;
         px.green = 8'hFF;
         px.red   = 8'hFF;
         if (roll >= 20) begin
            case ($urandom_range(0, 2))
               0:       px.blue  = 8'($urandom_range(0, 254));
               1:       px.green = 8'($urandom_range(0, 254));
               default: px.red   = 8'($urandom_range(0, 254));
            endcase
         end
      end else if (roll < 45) begin
         px.alpha = 8'h00;
      end
      return px;
   endfunction

   function automatic logic [DIM_W-1:0] pick_origin();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return DIM_W'($urandom_range(0, 12));
      if (roll < 75) return DIM_W'($urandom_range(4096, 8191));
      if (roll < 85) return DIM_W'($urandom_range(3, 24));
      if (roll < 92) begin
         case ($urandom_range(0, 3))
            0:       return DIM_W'(0);
            1:       return DIM_W'(4095);
            2:       return DIM_W'(4096);
            default: return DIM_W'(8191);
         endcase
      end
      return DIM_W'($urandom_range(0, 8191));
   endfunction

   function automatic logic [DIM_W-1:0] pick_icon_dim();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return '0;
      if (roll < 78) return DIM_W'($urandom_range(1, 8));
      if (roll < 88) return DIM_W'($urandom_range(9, 24));
      if (roll < 94) return DIM_W'($urandom_range(4096, 4097));
      if (roll < 96) return DIM_W'(8191);
      return DIM_W'($urandom_range(0, 8191));
   endfunction

   function automatic logic [DIM_W-1:0] pick_screen_dim();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return DIM_W'(MAX_DIM);
      if (roll < 85) return DIM_W'($urandom_range(1, 24));
      if (roll < 92) return DIM_W'(8191);
      if (roll < 96) return '0;
      return DIM_W'($urandom_range(0, 8191));
   endfunction

   // Only bit zero selects the format; the upper bits are sometimes set as well.
   function automatic logic [DIM_W-1:0] pick_format();
      logic [DIM_W-1:0] v;
      v = DIM_W'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) v[DIM_W-1:1] = (DIM_W-1)'($urandom);
      return v;
   endfunction

   task automatic queue_random_phase(bit write_all);
      int area;
      int count;
      if (write_all || $urandom_range(0, 1)) queue_write(REG_DEST_X, pick_origin());
      if (write_all || $urandom_range(0, 1)) queue_write(REG_DEST_Y, pick_origin());
      if (write_all || $urandom_range(0, 1)) queue_write(REG_ICON_WIDTH, pick_icon_dim());
      if (write_all || $urandom_range(0, 1)) queue_write(REG_ICON_HEIGHT, pick_icon_dim());
      if (write_all || $urandom_range(0, 1)) queue_write(REG_PIXEL_FORMAT, pick_format());
      if (write_all || $urandom_range(0, 1)) queue_write(REG_SCREEN_WIDTH, pick_screen_dim());
      if (write_all || $urandom_range(0, 1)) queue_write(REG_SCREEN_HEIGHT, pick_screen_dim());
      if ($urandom_range(0, 11) == 0) queue_write(REG_SPARE, DIM_W'($urandom));
      // Mostly whole icons, so the counters wrap cleanly; the rest may stop mid-icon.
      area = plan_w * plan_h;
      if (area > 0 && area <= 64 && $urandom_range(0, 99) < 75) begin
         count = area * $urandom_range(1, 3);
      end else begin
         count = $urandom_range(4, 48);
      end
      repeat (count) queue_pixel(random_pixel());
   endtask

   // Idle lengths: mostly none or short, a few long, with calm stretches of none.
   function automatic int pick_gap(inout int calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if (roll < 6) calm = $urandom_range(20, 80);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Driver: inputs change on the falling edge.
   always @(negedge clock) begin : drive_block
      blit_op_t head;
      logic     nxt_req_valid;
      logic     nxt_csr_valid;
      nxt_req_valid = req_valid;
      nxt_csr_valid = csr_valid;
      if (!reset) begin
         if (req_valid && req_took) nxt_req_valid = 1'b0;
         if (csr_valid && csr_took) nxt_csr_valid = 1'b0;
         if (!nxt_req_valid && !nxt_csr_valid && blit_ops.size() > 0) begin
            head = blit_ops[0];
            if (head.kind == ACT_CSR) begin
               // Registers change only once every pixel in flight has come out.
               if (quiet_cycles >= SETTLE_CYCLES) begin
                  void'(blit_ops.pop_front());
                  csr_index     <= head.idx;
                  csr_wdata     <= head.data;
                  nxt_csr_valid = 1'b1;
               end
            end else if (req_gap > 0) begin
               req_gap--;
            end else begin
               void'(blit_ops.pop_front());
               req_pix_blue  <= head.pix.blue;
               req_pix_green <= head.pix.green;
               req_pix_red   <= head.pix.red;
               req_pix_alpha <= head.pix.alpha;
               nxt_req_valid = 1'b1;
               req_gap       = pick_gap(req_calm);
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = pick_gap(rsp_calm);
         end
      end
      req_valid <= nxt_req_valid;
      csr_valid <= nxt_csr_valid;
   end

   // Monitor and scoreboard: everything is sampled on the rising edge.
   always @(posedge clock) begin : watch_block
      canvas_write_t got;
      canvas_write_t want;
      req_took = !reset && req_valid && req_ready;
      csr_took = !reset && csr_valid && csr_ready;
      rsp_took = !reset && rsp_valid && rsp_ready;
      if (req_took || csr_took || rsp_took) idle_run = 0;
      else idle_run++;
      if (csr_took) apply_csr(csr_index, csr_wdata);
      if (rsp_took) begin
         got = {rsp_write_enable, rsp_screen_col, rsp_screen_row, rsp_argb_color,
                rsp_icon_done};
         if (expected_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: we=%0b col=%0d row=%0d argb=%08h done=%0b",
                        got.we, got.col, got.row, got.argb, got.done);
         end else begin
            want = expected_writes.pop_front();
            if (got.we !== want.we || got.col !== want.col || got.row !== want.row ||
                got.argb !== want.argb || got.done !== want.done) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: expected we=%0b col=%0d row=%0d argb=%08h done=%0b, %s",
                           want.we, want.col, want.row, want.argb, want.done,
                           $sformatf("got we=%0b col=%0d row=%0d argb=%08h done=%0b",
                                     got.we, got.col, got.row, got.argb, got.done));
            end
         end
      end
      if (req_took)
         expected_writes.push_back(blit_pixel({req_pix_blue, req_pix_green, req_pix_red,
                                               req_pix_alpha}));
      quiet_cycles = (expected_writes.size() == 0 && !req_valid) ? quiet_cycles + 1 : 0;
   end

   initial begin : run_block
      bit timed_out;
      // Out of reset the icon is empty, so every pixel ends it at once.
      queue_pixel({8'h00, 8'h00, 8'h00, 8'h00});
      queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
      // A small icon in 24-bit format: white is keyed out, near-white is not.
      queue_write(REG_DEST_X, 13'd2);
      queue_write(REG_DEST_Y, 13'd1);
      queue_write(REG_ICON_WIDTH, 13'd3);
      queue_write(REG_ICON_HEIGHT, 13'd2);
      queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'h00});
      queue_pixel({8'hFE, 8'hFF, 8'hFF, 8'h00});
      queue_pixel({8'hFF, 8'hFE, 8'hFF, 8'h00});
      queue_pixel({8'hFF, 8'hFF, 8'hFE, 8'h00});
      queue_pixel({8'h00, 8'h00, 8'h00, 8'hFF});
      queue_pixel({8'h12, 8'h34, 8'h56, 8'h78});
      // 32-bit format: white passes, zero alpha is skipped; the icon stops mid-way.
      queue_write(REG_PIXEL_FORMAT, {12'd0, FMT_BGRA32});
      queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'h80});
      queue_pixel({8'h10, 8'h20, 8'h30, 8'h00});
      queue_pixel({8'hAA, 8'h55, 8'h0F, 8'h01});
      queue_pixel({8'h01, 8'h02, 8'h03, 8'hFF});
      // A small canvas clips the placed icon both ways.
      queue_write(REG_SCREEN_WIDTH, 13'd4);
      queue_write(REG_SCREEN_HEIGHT, 13'd2);
      repeat (6) queue_pixel(random_pixel());
      // Origin at the far corner of a full canvas, with an oversized width.
      queue_write(REG_SCREEN_WIDTH, 13'd4096);
      queue_write(REG_SCREEN_HEIGHT, 13'd4096);
      queue_write(REG_DEST_X, 13'd4095);
      queue_write(REG_DEST_Y, 13'd4095);
      queue_write(REG_ICON_WIDTH, 13'd8191);
      queue_write(REG_ICON_HEIGHT, 13'd1);
      queue_write(REG_PIXEL_FORMAT, {12'd0, FMT_BGR24});
      queue_pixel({8'h00, 8'h00, 8'h00, 8'h00});
      queue_pixel({8'h01, 8'h02, 8'h03, 8'h04});
      // Shrinking the width below the column counter ends the row.
      queue_write(REG_ICON_WIDTH, 13'd1);
      queue_pixel({8'h40, 8'h50, 8'h60, 8'h70});
      // Shrinking the height below the row counter leaves a row with no place.
      queue_write(REG_DEST_X, 13'd0);
      queue_write(REG_DEST_Y, 13'd0);
      queue_write(REG_ICON_HEIGHT, 13'd4);
      queue_pixel({8'h11, 8'h22, 8'h33, 8'h44});
      queue_pixel({8'h55, 8'h66, 8'h77, 8'h88});
      queue_write(REG_ICON_HEIGHT, 13'd2);
      queue_pixel({8'h99, 8'hAA, 8'hBB, 8'hCC});
      // The most negative origin draws nothing.
      queue_write(REG_DEST_X, 13'h1000);
      queue_pixel({8'hDD, 8'hEE, 8'h0F, 8'h1E});

      queue_random_phase(1'b1);
      while (planned_pixels < PIXEL_TARGET) queue_random_phase(1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(blit_ops.size() == 0 && !req_valid && !csr_valid &&
               expected_writes.size() == 0) && idle_run < STALL_LIMIT)
         @(posedge clock);
      timed_out = idle_run >= STALL_LIMIT;
      if (!timed_out) repeat (TAIL_CYCLES) @(posedge clock);
      if (!timed_out && mismatches == 0 && expected_writes.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/cib_pkg.sv
rtl/core/clipped_icon_blit_keyed.sv
dv/testbench.sv
